// File: rtl/core/pressure_sensor_compensation_macros.svh
// Assertion macros for the pressure sensor compensation block.
// Expects i_clk and i_rst_n in the scope of the module that uses them.
`ifndef PRESSURE_SENSOR_COMPENSATION_MACROS_SVH
`define PRESSURE_SENSOR_COMPENSATION_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/psc_pkg.sv
// Shared types and constants of the pressure sensor compensation block.
// No dependencies; every module of the block imports this package.
`default_nettype none

package psc_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int CAL_W     = 16;
    localparam int TEMP_W    = 19;
    localparam int PRESS_W   = 32;
    localparam int CFG_IDX_W = 3;

    // Calibration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SENS          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SENS_TEMPCO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_TEMPCO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_TEMP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_COEF     = 3'd5;

    // Temperature band limits in 0.01 C
    localparam logic signed [TEMP_W-1:0] TEMP_REF  = 19'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_VLOW = -19'sd1500;

    typedef struct packed {
        logic [SAMPLE_W-1:0] raw_pressure;
        logic [SAMPLE_W-1:0] raw_temperature;
    } t_sample;

    typedef struct packed {
        logic signed [TEMP_W-1:0]  temp_centi;
        logic signed [PRESS_W-1:0] press_deci;
    } t_result;

    typedef struct packed {
        logic [CAL_W-1:0] sens;
        logic [CAL_W-1:0] offset;
        logic [CAL_W-1:0] sens_tempco;
        logic [CAL_W-1:0] offset_tempco;
        logic [CAL_W-1:0] ref_temp;
        logic [CAL_W-1:0] temp_coef;
    } t_cal;

    // First-order results, handed from the front stages to the correction stages
    typedef struct packed {
        logic [SAMPLE_W-1:0]      d1;
        logic signed [TEMP_W-1:0] temp;
        logic                     low;
        logic [17:0]              ti;
        logic signed [36:0]       off;
        logic signed [35:0]       sens;
    } t_first;

    // Corrected offset and sensitivity, handed to the pressure stages
    typedef struct packed {
        logic [SAMPLE_W-1:0]      d1;
        logic signed [TEMP_W-1:0] t2;
        logic signed [41:0]       net_off;
        logic signed [41:0]       net_sens;
    } t_corr;

endpackage

`default_nettype wire

// File: rtl/core/pressure_sensor_compensation.sv
// Pressure sensor compensation: a nine-stage pipeline that takes one raw pressure
// and temperature pair per cycle and returns compensated temperature (0.01 C) and
// pressure (0.1 mbar, saturated to 32 bits). A request taken into the first stage shows
// its result on o_out_valid once it reaches the ninth stage register. The rate is one
// request per cycle; the only stall comes from a held result register, which freezes
// every stage together, so o_in_stall follows i_out_stall while a result is waiting;
// o_in_stall is also high during reset.
// The six calibration words are written through the configuration channel, which
// is ready whenever reset is released, and must not change while requests are in flight.
// Depends on psc_pkg, psc_cal_regs, psc_front, psc_second, psc_press and the macros header.
`default_nettype none
`include "pressure_sensor_compensation_macros.svh"

module pressure_sensor_compensation (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  psc_pkg::t_sample              i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output psc_pkg::t_result              o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [psc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [psc_pkg::CAL_W-1:0]     i_cfg_data
);
    import psc_pkg::*;

    t_cal   w_cal;
    logic   w_adv;
    logic   w_first_valid, w_corr_valid;
    t_first w_first;
    t_corr  w_corr;

    // hold the whole pipe while the result register is not taken
    assign w_adv      = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_adv || !i_rst_n;

    psc_cal_regs u_cal_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cal       (w_cal)
    );

    psc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_cal   (w_cal),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_valid (w_first_valid),
        .o_data  (w_first)
    );

    psc_second u_second (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_first_valid),
        .i_data  (w_first),
        .o_valid (w_corr_valid),
        .o_data  (w_corr)
    );

    psc_press u_press (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_corr_valid),
        .i_data  (w_corr),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

    `PSC_ASSERT_SAME(a_stall_needs_result, o_in_stall, o_out_valid, "input stalled without a waiting result")
    `PSC_ASSERT_NEXT(a_first_hold, o_in_stall, $stable(w_first) && $stable(w_first_valid), "first-order stage moved during stall")
    `PSC_ASSERT_NEXT(a_corr_hold, o_in_stall, $stable(w_corr) && $stable(w_corr_valid), "correction stage moved during stall")

endmodule

`default_nettype wire

// File: rtl/core/psc_cal_regs.sv
// Calibration word registers written through the configuration channel.
// Depends on psc_pkg.
`default_nettype none

module psc_cal_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [psc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [psc_pkg::CAL_W-1:0]     i_cfg_data,
    output psc_pkg::t_cal                 o_cal
);
    import psc_pkg::*;

    t_cal r_cal;

    // writes are taken only out of reset
    assign o_cfg_ready = i_rst_n;
    assign o_cal       = r_cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SENS:          r_cal.sens          <= i_cfg_data;
                CFG_OFFSET:        r_cal.offset        <= i_cfg_data;
                CFG_SENS_TEMPCO:   r_cal.sens_tempco   <= i_cfg_data;
                CFG_OFFSET_TEMPCO: r_cal.offset_tempco <= i_cfg_data;
                CFG_REF_TEMP:      r_cal.ref_temp      <= i_cfg_data;
                CFG_TEMP_COEF:     r_cal.temp_coef     <= i_cfg_data;
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/psc_front.sv
// First-order stages: temperature difference, the four products of it,
// then first-order temperature, offset, sensitivity and the Ti term.
// Depends on psc_pkg.
`default_nettype none

module psc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  psc_pkg::t_cal    i_cal,
    input  logic             i_valid,
    input  psc_pkg::t_sample i_data,
    output logic             o_valid,
    output psc_pkg::t_first  o_data
);
    import psc_pkg::*;

    // stage 1
    logic                     r_v1;
    logic [SAMPLE_W-1:0]      r_d1_s1;
    logic signed [24:0]       r_dt;
    logic signed [24:0]       n_dt;
    // stage 2
    logic                     r_v2;
    logic [SAMPLE_W-1:0]      r_d1_s2;
    logic signed [41:0]       r_mt, r_mo, r_ms;
    logic signed [41:0]       n_mt, n_mo, n_ms;
    logic signed [49:0]       r_dtsq;
    logic signed [49:0]       n_dtsq;
    // stage 3
    logic                     r_v3;
    t_first                   r_first;
    t_first                   n_first;
    logic [50:0]              n_sq3;

    assign n_dt = $signed({1'b0, i_data.raw_temperature})
                - $signed({1'b0, i_cal.ref_temp, 8'h00});

    assign n_mt   = r_dt * $signed({1'b0, i_cal.temp_coef});
    assign n_mo   = r_dt * $signed({1'b0, i_cal.offset_tempco});
    assign n_ms   = r_dt * $signed({1'b0, i_cal.sens_tempco});
    assign n_dtsq = r_dt * r_dt;

    // dT squared is never negative, so the Ti terms use plain unsigned shifts
    assign n_sq3 = {r_dtsq[49:0], 1'b0} + {1'b0, r_dtsq[49:0]};

    always_comb begin
        n_first.d1   = r_d1_s2;
        // floor shift of dT*C6 by 23 is negative exactly when TEMP is below 20.00 C
        n_first.temp = $signed(r_mt[41:23]) + TEMP_REF;
        n_first.low  = r_mt[41];
        n_first.ti   = r_mt[41] ? n_sq3[50:33] : {4'b0000, r_dtsq[49:36]};
        n_first.off  = $signed({5'b00000, i_cal.offset, 16'h0000})
                     + $signed({{2{r_mo[41]}}, r_mo[41:7]});
        n_first.sens = $signed({5'b00000, i_cal.sens, 15'h0000})
                     + $signed({{2{r_ms[41]}}, r_ms[41:8]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_d1_s1 <= i_data.raw_pressure;
            r_dt    <= n_dt;
            r_d1_s2 <= r_d1_s1;
            r_mt    <= n_mt;
            r_mo    <= n_mo;
            r_ms    <= n_ms;
            r_dtsq  <= n_dtsq;
            r_first <= n_first;
        end
    end

    assign o_valid = r_v3;
    assign o_data  = r_first;

endmodule

`default_nettype wire

// File: rtl/core/psc_second.sv
// Second-order correction stages: squared deviations, band selection of
// OFFi and SENSi, and the corrected offset and sensitivity.
// Depends on psc_pkg.
`default_nettype none

module psc_second (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic            i_valid,
    input  psc_pkg::t_first i_data,
    output logic            o_valid,
    output psc_pkg::t_corr  o_data
);
    import psc_pkg::*;

    // stage 4
    logic                     r_v4;
    logic [SAMPLE_W-1:0]      r_d1_s4;
    logic signed [TEMP_W-1:0] r_t2_s4;
    logic                     r_low, r_vlow;
    logic signed [36:0]       r_off_s4;
    logic signed [35:0]       r_sens_s4;
    logic [35:0]              r_sq, r_losq;
    logic signed [19:0]       n_dev, n_lo;
    logic signed [39:0]       n_sq, n_losq;
    // stage 5
    logic                     r_v5;
    logic [SAMPLE_W-1:0]      r_d1_s5;
    logic signed [TEMP_W-1:0] r_t2_s5;
    logic signed [36:0]       r_off_s5;
    logic signed [35:0]       r_sens_s5;
    logic [39:0]              r_offi, r_sensi;
    logic [39:0]              n_offi, n_sensi;
    logic [39:0]              n_sq3, n_sq5, n_lo7, n_lo4;
    // stage 6
    logic                     r_v6;
    t_corr                    r_corr;
    t_corr                    n_corr;

    assign n_dev  = {i_data.temp[TEMP_W-1], i_data.temp} - {TEMP_REF[TEMP_W-1], TEMP_REF};
    assign n_lo   = {i_data.temp[TEMP_W-1], i_data.temp} - {TEMP_VLOW[TEMP_W-1], TEMP_VLOW};
    assign n_sq   = n_dev * n_dev;
    assign n_losq = n_lo * n_lo;

    // squares stay below 2^35, so the scaled terms fit 40 bits unsigned
    assign n_sq3 = {4'h0, r_sq[34:0], 1'b0} + {4'h0, r_sq};
    assign n_sq5 = {4'h0, r_sq[33:0], 2'b00} + {4'h0, r_sq};
    assign n_lo7 = {1'b0, r_losq[35:0], 3'b000} - {4'h0, r_losq};
    assign n_lo4 = {2'b00, r_losq[35:0], 2'b00};

    always_comb begin
        if (r_low) begin
            n_offi  = {1'b0, n_sq3[39:1]} + (r_vlow ? n_lo7 : 40'd0);
            n_sensi = {3'b000, n_sq5[39:3]} + (r_vlow ? n_lo4 : 40'd0);
        end else begin
            n_offi  = {8'h00, r_sq[35:4]};
            n_sensi = '0;
        end
    end

    always_comb begin
        n_corr.d1       = r_d1_s5;
        n_corr.t2       = r_t2_s5;
        n_corr.net_off  = $signed({{5{r_off_s5[36]}}, r_off_s5}) - $signed({2'b00, r_offi});
        n_corr.net_sens = $signed({{6{r_sens_s5[35]}}, r_sens_s5}) - $signed({2'b00, r_sensi});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (i_adv) begin
            r_v4 <= i_valid;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_d1_s4   <= i_data.d1;
            r_t2_s4   <= i_data.temp - $signed({1'b0, i_data.ti});
            r_low     <= i_data.low;
            r_vlow    <= i_data.temp < TEMP_VLOW;
            r_off_s4  <= i_data.off;
            r_sens_s4 <= i_data.sens;
            r_sq      <= n_sq[35:0];
            r_losq    <= n_losq[35:0];

            r_d1_s5   <= r_d1_s4;
            r_t2_s5   <= r_t2_s4;
            r_off_s5  <= r_off_s4;
            r_sens_s5 <= r_sens_s4;
            r_offi    <= n_offi;
            r_sensi   <= n_sensi;

            r_corr    <= n_corr;
        end
    end

    assign o_valid = r_v6;
    assign o_data  = r_corr;

endmodule

`default_nettype wire

// File: rtl/core/psc_press.sv
// Pressure stages: D1 times corrected sensitivity as two partial products,
// offset subtraction, final shift and 32-bit saturation into the result register.
// Depends on psc_pkg.
`default_nettype none

module psc_press (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_valid,
    input  psc_pkg::t_corr   i_data,
    output logic             o_valid,
    output psc_pkg::t_result o_data
);
    import psc_pkg::*;

    // stage 7
    logic                     r_v7;
    logic signed [TEMP_W-1:0] r_t2_s7;
    logic signed [41:0]       r_off_s7;
    logic [44:0]              r_pp_lo;
    logic signed [45:0]       r_pp_hi;
    logic [44:0]              n_pp_lo;
    logic signed [45:0]       n_pp_hi;
    // stage 8
    logic                     r_v8;
    logic signed [TEMP_W-1:0] r_t2_s8;
    logic signed [47:0]       r_diff;
    logic signed [47:0]       n_diff;
    // stage 9
    logic                     r_v9;
    t_result                  r_res;
    logic signed [34:0]       n_p;
    logic signed [PRESS_W-1:0] n_press;

    assign n_pp_lo = {21'd0, i_data.d1} * {24'd0, i_data.net_sens[20:0]};
    assign n_pp_hi = $signed({1'b0, i_data.d1}) * $signed(i_data.net_sens[41:21]);

    // floor(D1*SENS / 2^21) = hi product + floor(lo product / 2^21), lo product >= 0
    assign n_diff = $signed({{2{r_pp_hi[45]}}, r_pp_hi})
                  + $signed({24'd0, r_pp_lo[44:21]})
                  - $signed({{6{r_off_s7[41]}}, r_off_s7});

    assign n_p = $signed(r_diff[47:13]);

    always_comb begin
        if ((n_p[34:31] == 4'b0000) || (n_p[34:31] == 4'b1111)) begin
            n_press = n_p[31:0];
        end else if (n_p[34]) begin
            n_press = {1'b1, {(PRESS_W-1){1'b0}}};
        end else begin
            n_press = {1'b0, {(PRESS_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
            r_v9 <= 1'b0;
        end else if (i_adv) begin
            r_v7 <= i_valid;
            r_v8 <= r_v7;
            r_v9 <= r_v8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_t2_s7          <= i_data.t2;
            r_off_s7         <= i_data.net_off;
            r_pp_lo          <= n_pp_lo;
            r_pp_hi          <= n_pp_hi;
            r_t2_s8          <= r_t2_s7;
            r_diff           <= n_diff;
            r_res.temp_centi <= r_t2_s8;
            r_res.press_deci <= n_press;
        end
    end

    assign o_valid = r_v9;
    assign o_data  = r_res;

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the pressure sensor compensation pipeline.
// Feeds raw pressure/temperature requests, predicts the compensated readings
// and checks them in order; depends only on psc_pkg and the block itself.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import psc_pkg::*;

    localparam int     HALF_PERIOD  = 5;
    localparam int     RESET_CYCLES = 6;
    localparam int     LATENCY      = 9;
    localparam int     DRAIN_CYCLES = LATENCY + 3;
    localparam int     MAX_REPORTS  = 10;
    localparam int     HEAVY_PCT    = 58;
    localparam int     LIGHT_PCT    = 7;
    localparam int     HOLD_CYCLES  = 80;
    localparam longint TIMEOUT_NS   = 5_000_000;

    // Indexes past the last calibration word; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam longint PRESS_MAX = 64'sd2147483647;
    localparam longint PRESS_MIN = -64'sd2147483648;

    localparam logic [SAMPLE_W-1:0] RAW_MAX      = '1;
    localparam logic [SAMPLE_W-1:0] MID_PRESSURE = 24'd4958179;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                 in_valid  = 1'b0;
    t_sample              in_data   = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CAL_W-1:0]     cfg_data  = '0;

    logic    o_in_stall;
    logic    o_out_valid;
    t_result o_out_data;
    logic    o_cfg_ready;

    t_cal    cal = '0;
    t_sample raw_pairs_q[$];
    t_result expected_readings_q[$];

    logic running  = 1'b0;
    logic in_taken = 1'b0;
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    int   hold_left     = 0;
    int   mismatches    = 0;
    int   accepted      = 0;
    int   checked       = 0;
    int   cal_sets      = 1;

    pressure_sensor_compensation i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Second-order compensation of one raw pair under calibration c
    function automatic t_result compensate(t_sample s, t_cal c);
        longint  d1, d2, dt, temp, off, sens, dev, sq, ti, offi, sensi, cold, p, t2;
        t_result r;
        d1   = longint'(s.raw_pressure);
        d2   = longint'(s.raw_temperature);
        dt   = d2 - longint'(c.ref_temp) * 256;
        temp = longint'(TEMP_REF) + ((dt * longint'(c.temp_coef)) >>> 23);
        off  = longint'(c.offset) * 65536 + ((longint'(c.offset_tempco) * dt) >>> 7);
        sens = longint'(c.sens) * 32768 + ((longint'(c.sens_tempco) * dt) >>> 8);
        dev  = temp - longint'(TEMP_REF);
        sq   = dev * dev;
        if (temp < longint'(TEMP_REF)) begin
            ti    = (3 * dt * dt) >> 33;
            offi  = (3 * sq) / 2;
            sensi = (5 * sq) / 8;
            if (temp < longint'(TEMP_VLOW)) begin
                cold  = temp - longint'(TEMP_VLOW);
                offi  += 7 * cold * cold;
                sensi += 4 * cold * cold;
            end
        end else begin
            ti    = (2 * dt * dt) >> 37;
            offi  = sq / 16;
            sensi = 0;
        end
        t2 = temp - ti;
        p  = (((d1 * (sens - sensi)) >>> 21) - (off - offi)) >>> 13;
        if (p > PRESS_MAX) p = PRESS_MAX;
        if (p < PRESS_MIN) p = PRESS_MIN;
        r.temp_centi = t2[TEMP_W-1:0];
        r.press_deci = p[PRESS_W-1:0];
        return r;
    endfunction

    // Mostly temperatures spread around the reference point, some fully random
    function automatic t_sample random_pair(t_cal c);
        t_sample s;
        longint  spread, d2;
        s.raw_pressure = SAMPLE_W'($urandom());
        case ($urandom_range(15))
            0:       s.raw_pressure = '0;
            1:       s.raw_pressure = RAW_MAX;
            default: ;
        endcase
        if ($urandom_range(4) == 0) begin
            s.raw_temperature = SAMPLE_W'($urandom());
        end else begin
            case ($urandom_range(2))
                0:       spread = 4096;
                1:       spread = 1 << 20;
                default: spread = 1 << 23;
            endcase
            d2 = longint'(c.ref_temp) * 256 + longint'($urandom_range(2 * spread)) - spread;
            if (d2 < 0) d2 = 0;
            if (d2 > longint'(RAW_MAX)) d2 = longint'(RAW_MAX);
            s.raw_temperature = d2[SAMPLE_W-1:0];
        end
        return s;
    endfunction

    task automatic note_mismatch(input string field, input longint expv, input longint got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, expv, got);
    endtask

    // Record requests and check readings against the oldest prediction
    always @(posedge i_clk) begin
        t_result exp_r;
        in_taken <= in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (in_valid && !o_in_stall) begin
                expected_readings_q.push_back(compensate(in_data, cal));
                accepted++;
            end
            if (o_out_valid && !out_stall) begin
                if (expected_readings_q.size() == 0) begin
                    note_mismatch("unrequested reading, temp_centi", 0,
                                  longint'(o_out_data.temp_centi));
                end else begin
                    exp_r = expected_readings_q.pop_front();
                    checked++;
                    if (o_out_data.temp_centi !== exp_r.temp_centi)
                        note_mismatch("temp_centi", longint'(exp_r.temp_centi),
                                      longint'(o_out_data.temp_centi));
                    if (o_out_data.press_deci !== exp_r.press_deci)
                        note_mismatch("press_deci", longint'(exp_r.press_deci),
                                      longint'(o_out_data.press_deci));
                end
            end
        end
    end

    // Request driver: hold a stalled request, otherwise advance or idle at random
    always @(negedge i_clk) begin
        if (running && (!in_valid || in_taken)) begin
            if (raw_pairs_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_data  <= raw_pairs_q.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Reading side: long hold-off when asked, otherwise random stalls
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic write_cal(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SENS:          cal.sens          = val;
            CFG_OFFSET:        cal.offset        = val;
            CFG_SENS_TEMPCO:   cal.sens_tempco   = val;
            CFG_OFFSET_TEMPCO: cal.offset_tempco = val;
            CFG_REF_TEMP:      cal.ref_temp      = val;
            CFG_TEMP_COEF:     cal.temp_coef     = val;
            default:           ;
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_cal(input t_cal c);
        write_cal(CFG_SENS, c.sens);
        write_cal(CFG_OFFSET, c.offset);
        write_cal(CFG_SENS_TEMPCO, c.sens_tempco);
        write_cal(CFG_OFFSET_TEMPCO, c.offset_tempco);
        write_cal(CFG_REF_TEMP, c.ref_temp);
        write_cal(CFG_TEMP_COEF, c.temp_coef);
        cal_sets++;
    endtask

    task automatic wait_idle();
        while (raw_pairs_q.size() != 0 || in_valid || expected_readings_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_pair(input logic [SAMPLE_W-1:0] d1, input logic [SAMPLE_W-1:0] d2);
        t_sample s;
        s.raw_pressure    = d1;
        s.raw_temperature = d2;
        raw_pairs_q.push_back(s);
    endtask

    // Temperature given as distance from the reference reading
    task automatic push_offset(input logic [SAMPLE_W-1:0] d1, input longint dt);
        longint d2;
        d2 = longint'(cal.ref_temp) * 256 + dt;
        if (d2 < 0) d2 = 0;
        if (d2 > longint'(RAW_MAX)) d2 = longint'(RAW_MAX);
        push_pair(d1, d2[SAMPLE_W-1:0]);
    endtask

    task automatic push_random(input int count);
        repeat (count) raw_pairs_q.push_back(random_pair(cal));
    endtask

    initial begin
        #(TIMEOUT_NS * 1ns);
        $display("Timeout with %0d readings outstanding", expected_readings_q.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        t_cal   typical;
        t_cal   rand_cal;
        longint cold_dt;

        typical.sens          = 16'd34982;
        typical.offset        = 16'd36352;
        typical.sens_tempco   = 16'd20328;
        typical.offset_tempco = 16'd22354;
        typical.ref_temp      = 16'd26646;
        typical.temp_coef     = 16'd26146;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        running <= 1'b1;
        @(posedge i_clk);

        // Calibration left at reset: all words zero
        push_pair('0, '0);
        push_pair(RAW_MAX, RAW_MAX);
        push_pair(RAW_MAX, '0);
        push_pair('0, RAW_MAX);
        wait_idle();
        write_cal(CFG_SPARE_LO, 16'hA5A5);
        write_cal(CFG_SPARE_HI, 16'h5A5A);

        // Typical calibration: band edges, then random requests without idling
        load_cal(typical);
        cold_dt = -(((longint'(TEMP_REF) - longint'(TEMP_VLOW)) <<< 23)
                    / longint'(cal.temp_coef));
        push_offset(MID_PRESSURE, 0);
        push_offset(MID_PRESSURE, -1);
        push_offset(MID_PRESSURE, 1);
        push_offset(MID_PRESSURE, 2_000_000);
        push_offset(RAW_MAX, 2_000_000);
        push_offset(MID_PRESSURE, cold_dt);
        push_offset(MID_PRESSURE, cold_dt - 1);
        push_offset('0, cold_dt - 1);
        push_offset(RAW_MAX, cold_dt - 1);
        push_pair(MID_PRESSURE, '0);
        push_pair(MID_PRESSURE, RAW_MAX);
        push_pair(RAW_MAX, '0);
        push_pair('0, RAW_MAX);
        push_random(300);
        wait_idle();

        // Hold off the reading side so the pipeline fills and stalls its input
        hold_left = HOLD_CYCLES;
        push_random(60);
        wait_idle();

        // All-ones calibration with a sparse sender and a full drain midway
        load_cal('1);
        send_idle_pct = HEAVY_PCT;
        push_random(100);
        wait_idle();
        push_random(100);
        wait_idle();

        send_idle_pct = 0;
        stall_pct     = HEAVY_PCT;
        rand_cal      = {$urandom(), $urandom(), $urandom()};
        load_cal(rand_cal);
        push_random(250);
        wait_idle();

        send_idle_pct = LIGHT_PCT;
        stall_pct     = LIGHT_PCT;
        rand_cal      = {$urandom(), $urandom(), $urandom()};
        load_cal(rand_cal);
        push_random(125);
        wait_idle();
        rand_cal = {$urandom(), $urandom(), $urandom()};
        load_cal(rand_cal);
        push_random(125);
        wait_idle();

        $display("Checked %0d readings from %0d requests over %0d calibration sets, %0d bad",
                 checked, accepted, cal_sets, mismatches);
        $display("Ran high, low and very-low bands with idle, stalled and held-off traffic");
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: pressure_sensor_compensation.f
+incdir+rtl/core
rtl/core/psc_pkg.sv
rtl/core/psc_cal_regs.sv
rtl/core/psc_front.sv
rtl/core/psc_second.sv
rtl/core/psc_press.sv
rtl/core/pressure_sensor_compensation.sv
tb/testbench.sv
